/* src/lru_page_table_top_defines.svh */
// ----------------------------------------------------------------------------
// lru_page_table_top_defines.svh
// Assertion macros shared by the page table RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_TABLE_TOP_DEFINES_SVH
`define LRU_PAGE_TABLE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LPT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define LPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lpt_pkg.sv */
// ----------------------------------------------------------------------------
// lpt_pkg
// Action codes and controller states of the page table.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam logic [2:0] ACT_FIND   = 3'd0;
  localparam logic [2:0] ACT_TOUCH  = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam int unsigned COORD_BITS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_LNK_RD,
    ST_LNK_WAIT,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_REM_RD,
    ST_REM_WAIT,
    ST_DONE
  } lpt_state_e;

endpackage

/* src/lru_page_table_top.sv */
// Order of work: find sweeps every slot before the result; add and touch may
// then run the link updates; remove reads the oldest entry, and clear, remove
// on an empty table and unused codes go straight to the result. One transaction
// is in work at a time, so the next is taken only after a result is stored. The
// key search sweeps the data RAM one slot a cycle over its read port. Reset is
// asynchronous and active low; it empties the table at once.
// ----------------------------------------------------------------------------
// lru_page_table_top
// Fully associative page tag store kept in least-recently-used order.
// ----------------------------------------------------------------------------
`include "lru_page_table_top_defines.svh"

module lru_page_table_top #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      action_i,
  input  logic [KEY_BITS-1:0]             page_key_i,
  input  logic [7:0]                      slot_x_i,
  input  logic [7:0]                      slot_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ok_o,
  output logic                            hit_o,
  output logic [KEY_BITS-1:0]             evicted_key_o,
  output logic [7:0]                      evicted_x_o,
  output logic [7:0]                      evicted_y_o,
  output logic [$clog2(CAPACITY+1)-1:0]   occupancy_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = lpt_pkg::COORD_BITS;
  localparam int unsigned DW = KEY_BITS + 2 * CW;
  localparam int unsigned LW = 2 * IW;

  // Controller state and the working copy of the current transaction.
  lpt_pkg::lpt_state_e state_q, state_d;
  logic [2:0]          action_q, action_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CW-1:0]       x_q, x_d, y_q, y_d;

  // Table bookkeeping. The valid bits live in flops so reset clears them.
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [IW-1:0]       newest_q, newest_d, oldest_q, oldest_d;
  logic [OW-1:0]       used_q, used_d;

  // Search sweep: the read is issued at cnt, compared in the next cycle at cmp_idx.
  logic [IW-1:0] cnt_q, cnt_d, cmp_idx_q, cmp_idx_d;
  logic          cmp_valid_q, cmp_valid_d;
  logic          hit_q, hit_d, free_found_q, free_found_d;
  logic [IW-1:0] hit_slot_q, hit_slot_d, free_slot_q, free_slot_d;

  // Link rewrite sequencer. Slot t is the one moved to the newest end; n and o
  // are its former neighbors.
  logic [IW-1:0] t_q, t_d, n_q, n_d, o_q, o_d;
  logic [1:0]    step_q, step_d;

  logic          ok_q, ok_d;
  logic [KEY_BITS-1:0] ev_key_q, ev_key_d;
  logic [CW-1:0] ev_x_q, ev_x_d, ev_y_q, ev_y_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic                ok_out_q, ok_out_d, hit_out_q, hit_out_d;
  logic [KEY_BITS-1:0] ek_out_q, ek_out_d;
  logic [CW-1:0]       ex_out_q, ex_out_d, ey_out_q, ey_out_d;
  logic [OW-1:0]       occ_out_q, occ_out_d;

  // RAM ports.
  logic          data_we, data_re, link_we, link_re;
  logic [IW-1:0] data_waddr, data_raddr, link_waddr, link_raddr;
  logic [DW-1:0] data_wdata, data_rdata;
  logic [LW-1:0] link_wdata, link_rdata;
  logic [IW-1:0] rd_newer, rd_older, op_addr;
  logic [LW-1:0] op_word;
  logic [KEY_BITS-1:0] rd_key;

  lpt_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  lpt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  assign rd_key   = data_rdata[DW-1 -: KEY_BITS];
  assign rd_newer = link_rdata[LW-1 -: IW];
  assign rd_older = link_rdata[IW-1:0];

  // Each link rewrite changes one half of an entry and keeps the other half
  // from the read just made, so steps that touch the same entry do not undo each other.
  always_comb begin
    case (step_q)
      2'd0: begin
        op_addr = o_q;
        op_word = {n_q, rd_older};
      end
      2'd1: begin
        op_addr = n_q;
        op_word = {rd_newer, o_q};
      end
      2'd2: begin
        op_addr = t_q;
        op_word = {rd_newer, newest_q};
      end
      default: begin
        op_addr = newest_q;
        op_word = {t_q, rd_older};
      end
    endcase
  end

  assign in_ready_o = (state_q == lpt_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    action_d     = action_q;
    key_d        = key_q;
    x_d          = x_q;
    y_d          = y_q;
    valid_d      = valid_q;
    newest_d     = newest_q;
    oldest_d     = oldest_q;
    used_d       = used_q;
    cnt_d        = cnt_q;
    cmp_idx_d    = cnt_q;
    cmp_valid_d  = 1'b0;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    hit_slot_d   = hit_slot_q;
    free_slot_d  = free_slot_q;
    t_d          = t_q;
    n_d          = n_q;
    o_d          = o_q;
    step_d       = step_q;
    ok_d         = ok_q;
    ev_key_d     = ev_key_q;
    ev_x_d       = ev_x_q;
    ev_y_d       = ev_y_q;
    out_valid_d  = out_valid_q;
    ok_out_d     = ok_out_q;
    hit_out_d    = hit_out_q;
    ek_out_d     = ek_out_q;
    ex_out_d     = ex_out_q;
    ey_out_d     = ey_out_q;
    occ_out_d    = occ_out_q;
    data_we      = 1'b0;
    data_waddr   = t_q;
    data_wdata   = {key_q, x_q, y_q};
    data_re      = 1'b0;
    data_raddr   = cnt_q;
    link_we      = 1'b0;
    link_waddr   = op_addr;
    link_wdata   = op_word;
    link_re      = 1'b0;
    link_raddr   = op_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Compare stage of the sweep: the first match is the hit and the first
    // empty slot is where an add lands.
    if (cmp_valid_q) begin
      if (valid_q[cmp_idx_q] && (rd_key == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = cmp_idx_q;
      end
      if (!valid_q[cmp_idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_slot_d  = cmp_idx_q;
      end
    end

    case (state_q)
      lpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          action_d     = action_i;
          key_d        = page_key_i;
          x_d          = slot_x_i;
          y_d          = slot_y_i;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          ok_d         = 1'b0;
          ev_key_d     = '0;
          ev_x_d       = '0;
          ev_y_d       = '0;
          cnt_d        = '0;
          state_d      = lpt_pkg::ST_DONE;
          case (action_i)
            lpt_pkg::ACT_FIND, lpt_pkg::ACT_TOUCH, lpt_pkg::ACT_ADD: begin
              state_d = lpt_pkg::ST_SCAN;
            end
            lpt_pkg::ACT_REMOVE: begin
              if (used_q != '0) begin
                state_d = lpt_pkg::ST_REM_RD;
              end
            end
            lpt_pkg::ACT_CLEAR: begin
              valid_d  = '0;
              newest_d = '0;
              oldest_d = '0;
              used_d   = '0;
            end
            default: begin
              state_d = lpt_pkg::ST_DONE;
            end
          endcase
        end
      end
      lpt_pkg::ST_SCAN: begin
        data_re     = 1'b1;
        cmp_valid_d = 1'b1;
        cnt_d       = cnt_q + IW'(1);
        if (cnt_q == IW'(CAPACITY - 1)) begin
          state_d = lpt_pkg::ST_SCAN_END;
        end
      end
      lpt_pkg::ST_SCAN_END: begin
        state_d = lpt_pkg::ST_DECIDE;
      end
      lpt_pkg::ST_DECIDE: begin
        state_d = lpt_pkg::ST_DONE;
        if (action_q == lpt_pkg::ACT_TOUCH) begin
          if (hit_q && (used_q > OW'(1)) && (hit_slot_q != newest_q)) begin
            t_d     = hit_slot_q;
            state_d = lpt_pkg::ST_LNK_RD;
          end
        end else if (action_q == lpt_pkg::ACT_ADD) begin
          if (!hit_q && free_found_q) begin
            data_we    = 1'b1;
            data_waddr = free_slot_q;
            t_d        = free_slot_q;
            valid_d[free_slot_q] = 1'b1;
            used_d     = used_q + OW'(1);
            ok_d       = 1'b1;
            if (used_q == '0) begin
              newest_d = free_slot_q;
              oldest_d = free_slot_q;
            end else begin
              step_d  = 2'd2;
              state_d = lpt_pkg::ST_RMW_RD;
            end
          end
        end
      end
      lpt_pkg::ST_LNK_RD: begin
        link_re    = 1'b1;
        link_raddr = t_q;
        state_d    = lpt_pkg::ST_LNK_WAIT;
      end
      lpt_pkg::ST_LNK_WAIT: begin
        n_d = rd_newer;
        o_d = rd_older;
        if (t_q == oldest_q) begin
          oldest_d = rd_newer;
          step_d   = 2'd2;
        end else begin
          step_d = 2'd0;
        end
        state_d = lpt_pkg::ST_RMW_RD;
      end
      lpt_pkg::ST_RMW_RD: begin
        link_re = 1'b1;
        state_d = lpt_pkg::ST_RMW_WR;
      end
      lpt_pkg::ST_RMW_WR: begin
        link_we = 1'b1;
        if (step_q == 2'd3) begin
          newest_d = t_q;
          state_d  = lpt_pkg::ST_DONE;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = lpt_pkg::ST_RMW_RD;
        end
      end
      lpt_pkg::ST_REM_RD: begin
        data_re    = 1'b1;
        data_raddr = oldest_q;
        link_re    = 1'b1;
        link_raddr = oldest_q;
        state_d    = lpt_pkg::ST_REM_WAIT;
      end
      lpt_pkg::ST_REM_WAIT: begin
        ev_key_d = rd_key;
        ev_x_d   = data_rdata[2*CW-1 -: CW];
        ev_y_d   = data_rdata[CW-1:0];
        valid_d[oldest_q] = 1'b0;
        ok_d     = 1'b1;
        used_d   = used_q - OW'(1);
        if (used_q == OW'(1)) begin
          newest_d = '0;
          oldest_d = '0;
        end else begin
          oldest_d = rd_newer;
        end
        state_d = lpt_pkg::ST_DONE;
      end
      lpt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_out_d    = ok_q;
          hit_out_d   = hit_q && ((action_q == lpt_pkg::ACT_FIND) ||
                                  (action_q == lpt_pkg::ACT_TOUCH) ||
                                  (action_q == lpt_pkg::ACT_ADD));
          ek_out_d    = ev_key_q;
          ex_out_d    = ev_x_q;
          ey_out_d    = ev_y_q;
          occ_out_d   = used_q;
          state_d     = lpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpt_pkg::ST_IDLE;
      valid_q     <= '0;
      newest_q    <= '0;
      oldest_q    <= '0;
      used_q      <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      used_q      <= used_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    key_q        <= key_d;
    x_q          <= x_d;
    y_q          <= y_d;
    cnt_q        <= cnt_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    hit_slot_q   <= hit_slot_d;
    free_slot_q  <= free_slot_d;
    t_q          <= t_d;
    n_q          <= n_d;
    o_q          <= o_d;
    step_q       <= step_d;
    ok_q         <= ok_d;
    ev_key_q     <= ev_key_d;
    ev_x_q       <= ev_x_d;
    ev_y_q       <= ev_y_d;
    ok_out_q     <= ok_out_d;
    hit_out_q    <= hit_out_d;
    ek_out_q     <= ek_out_d;
    ex_out_q     <= ex_out_d;
    ey_out_q     <= ey_out_d;
    occ_out_q    <= occ_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_out_q;
  assign hit_o         = hit_out_q;
  assign evicted_key_o = ek_out_q;
  assign evicted_x_o   = ex_out_q;
  assign evicted_y_o   = ey_out_q;
  assign occupancy_o   = occ_out_q;

  // The fill count always equals the number of valid slots and never passes
  // the capacity; one transaction is in work at a time.
  `LPT_ASSERT_ALWAYS(a_occ_max, used_q <= OW'(CAPACITY), "occupancy above capacity")
  `LPT_ASSERT_ALWAYS(a_occ_valid, $countones(valid_q) == int'(used_q), "count mismatch")
  `LPT_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second accept")

endmodule

/* src/lpt_ram.sv */
// ----------------------------------------------------------------------------
// lpt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
